// ===== design/oss_pkg.sv =====
package oss_pkg;

  localparam int SW = 64;
  localparam int EW = 32;
  localparam int RW = 7;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_MOVE   = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SHUP_RD,
    S_SHUP_WR,
    S_INS_WR,
    S_SHDN_RD,
    S_SHDN_WR,
    S_RNG_RD,
    S_RNG_EM,
    S_EMIT1
  } state_t;

  typedef struct packed {
    logic less;
    logic equal;
  } cmp_res_t;

endpackage

// ===== design/oss_if.sv =====
interface oss_in_if import oss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           operation;
  logic signed [SW-1:0] score;
  logic [EW-1:0]        element;
  logic signed [SW-1:0] new_score;
  logic [RW-1:0]        rank_start;
  logic [RW-1:0]        rank_end;

  modport source (output valid, operation, score, element, new_score, rank_start, rank_end,
                  input ready);
  modport sink (input valid, operation, score, element, new_score, rank_start, rank_end,
                output ready);
endinterface

interface oss_out_if import oss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [EW-1:0]        out_element;
  logic signed [SW-1:0] out_score;
  logic [RW-1:0]        entry_count;
  logic                 last;

  modport source (output valid, status, out_element, out_score, entry_count, last,
                  input ready);
  modport sink (input valid, status, out_element, out_score, entry_count, last,
                output ready);
endinterface

interface oss_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/oss_ram.sv =====
module oss_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/oss_cmp.sv =====
module oss_cmp import oss_pkg::*; (
  input  logic signed [SW-1:0] a_score,
  input  logic [EW-1:0]        a_elem,
  input  logic signed [SW-1:0] b_score,
  input  logic [EW-1:0]        b_elem,
  output cmp_res_t             res
);

  always_comb begin
    res.equal = (a_score == b_score) && (a_elem == b_elem);
    res.less  = (a_score < b_score) || ((a_score == b_score) && (a_elem < b_elem));
  end

endmodule

// ===== design/ordered_score_set.sv =====
// Sorted table of up to CAPACITY (score, element) pairs held in one single-port-read RAM and
// kept in ascending order by score then element. A small sequencer drives one shared key
// comparator and the RAM: each entry visited by the position scan is read and then compared,
// each entry shifted during insert or delete is read and then written, and each range result
// is read and then emitted, waiting while the output register still holds an untaken result.
// The input is not ready while an item is in progress; the last result sits in an output
// register so the next item can start before it is taken. reverse_order may be written at any
// idle time through the cfg channel, which is always ready.
module ordered_score_set import oss_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  oss_in_if.sink    in_ch,
  oss_out_if.source out_ch,
  oss_cfg_if.sink   cfg_ch
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = SW + EW;

  state_t state_r, state_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic rev_r;
  logic [2:0] op_r, op_nxt;
  logic phase_r, phase_nxt;
  logic signed [SW-1:0] key_s_r, key_s_nxt, ns_r, ns_nxt;
  logic [EW-1:0] key_e_r, key_e_nxt;
  logic [CW-1:0] idx_r, idx_nxt, pos_r, pos_nxt, end_r, end_nxt, cnt_r, cnt_nxt;
  logic rrev_r, rrev_nxt, rem_r, rem_nxt;
  logic [1:0] em_st_r, em_st_nxt;
  logic [EW-1:0] em_e_r, em_e_nxt;
  logic signed [SW-1:0] em_s_r, em_s_nxt;

  logic ov_r, ov_nxt;
  logic [1:0] o_st_r, o_st_nxt;
  logic [EW-1:0] o_e_r, o_e_nxt;
  logic signed [SW-1:0] o_s_r, o_s_nxt;
  logic [CW-1:0] o_cnt_r, o_cnt_nxt;
  logic o_last_r, o_last_nxt;

  logic we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic signed [SW-1:0] rd_s;
  logic [EW-1:0] rd_e;
  cmp_res_t cmp;

  logic out_free;
  logic [RW-1:0] occ_w, first_w, stop_w, rstop_w;
  logic [CW-1:0] rng_addr;

  assign rd_s = rdata[DW-1:EW];
  assign rd_e = rdata[EW-1:0];

  oss_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  oss_cmp u_cmp (
    .a_score(rd_s), .a_elem(rd_e), .b_score(key_s_r), .b_elem(key_e_r), .res(cmp)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = o_st_r;
  assign out_ch.out_element = o_e_r;
  assign out_ch.out_score   = o_s_r;
  assign out_ch.entry_count = RW'(o_cnt_r);
  assign out_ch.last        = o_last_r;

  assign out_free = !ov_r || out_ch.ready;
  assign occ_w    = RW'(occ_r);
  assign first_w  = (in_ch.rank_start == '0) ? RW'(1) : in_ch.rank_start;
  assign stop_w   = (in_ch.rank_end > occ_w) ? occ_w : in_ch.rank_end;
  assign rstop_w  = (in_ch.rank_end >= occ_w) ? (occ_w - RW'(1)) : in_ch.rank_end;
  assign rng_addr = rrev_r ? (occ_r - CW'(1) - idx_r) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      rev_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid) begin
        rev_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    phase_r  <= phase_nxt;
    key_s_r  <= key_s_nxt;
    key_e_r  <= key_e_nxt;
    ns_r     <= ns_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    cnt_r    <= cnt_nxt;
    rrev_r   <= rrev_nxt;
    rem_r    <= rem_nxt;
    em_st_r  <= em_st_nxt;
    em_e_r   <= em_e_nxt;
    em_s_r   <= em_s_nxt;
    o_st_r   <= o_st_nxt;
    o_e_r    <= o_e_nxt;
    o_s_r    <= o_s_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    op_nxt     = op_r;
    phase_nxt  = phase_r;
    key_s_nxt  = key_s_r;
    key_e_nxt  = key_e_r;
    ns_nxt     = ns_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    end_nxt    = end_r;
    cnt_nxt    = cnt_r;
    rrev_nxt   = rrev_r;
    rem_nxt    = rem_r;
    em_st_nxt  = em_st_r;
    em_e_nxt   = em_e_r;
    em_s_nxt   = em_s_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_st_nxt   = o_st_r;
    o_e_nxt    = o_e_r;
    o_s_nxt    = o_s_r;
    o_cnt_nxt  = o_cnt_r;
    o_last_nxt = o_last_r;
    we         = 1'b0;
    waddr      = pos_r[AW-1:0];
    wdata      = rdata;
    re         = 1'b0;
    raddr      = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          key_s_nxt = in_ch.score;
          key_e_nxt = in_ch.element;
          ns_nxt    = in_ch.new_score;
          phase_nxt = 1'b0;
          rem_nxt   = 1'b0;
          rrev_nxt  = 1'b0;
          idx_nxt   = '0;
          em_st_nxt = ST_OK;
          em_e_nxt  = '0;
          em_s_nxt  = '0;
          cnt_nxt   = occ_r;
          unique case (in_ch.operation)
            OP_INSERT: begin
              if (occ_w >= RW'(CAPACITY)) begin
                em_st_nxt = ST_FULL;
                state_nxt = S_EMIT1;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            OP_DELETE, OP_MOVE: begin
              state_nxt = S_SCAN_RD;
            end
            OP_GET: begin
              if (in_ch.rank_start == '0 || in_ch.rank_start > occ_w) begin
                em_st_nxt = ST_NOTFOUND;
                state_nxt = S_EMIT1;
              end else begin
                idx_nxt   = CW'(in_ch.rank_start - RW'(1));
                end_nxt   = CW'(in_ch.rank_start - RW'(1));
                state_nxt = S_RNG_RD;
              end
            end
            OP_REMOVE: begin
              if (first_w > stop_w) begin
                em_st_nxt = ST_EMPTY;
                state_nxt = S_EMIT1;
              end else begin
                idx_nxt   = CW'(first_w - RW'(1));
                pos_nxt   = CW'(first_w - RW'(1));
                end_nxt   = CW'(stop_w - RW'(1));
                cnt_nxt   = CW'(occ_w - (stop_w - first_w + RW'(1)));
                rem_nxt   = 1'b1;
                state_nxt = S_RNG_RD;
              end
            end
            OP_READ: begin
              if (in_ch.rank_end < in_ch.rank_start || in_ch.rank_start >= occ_w) begin
                em_st_nxt = ST_EMPTY;
                state_nxt = S_EMIT1;
              end else begin
                idx_nxt   = CW'(in_ch.rank_start);
                end_nxt   = CW'(rstop_w);
                rrev_nxt  = rev_r;
                state_nxt = S_RNG_RD;
              end
            end
            default: begin
              state_nxt = S_EMIT1;
            end
          endcase
        end
      end
      S_SCAN_RD, S_SCAN_EV: begin
        if (state_r == S_SCAN_RD && idx_r != occ_r) begin
          re        = 1'b1;
          state_nxt = S_SCAN_EV;
        end else if (state_r == S_SCAN_EV && cmp.less) begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SCAN_RD;
        end else begin
          pos_nxt = idx_r;
          if (op_r == OP_INSERT || phase_r) begin
            idx_nxt   = occ_r;
            state_nxt = S_SHUP_RD;
          end else if (state_r == S_SCAN_EV && cmp.equal) begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_SHDN_RD;
          end else begin
            em_st_nxt = ST_NOTFOUND;
            state_nxt = S_EMIT1;
          end
        end
      end
      S_SHUP_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = S_INS_WR;
        end else begin
          re        = 1'b1;
          raddr     = AW'(idx_r - CW'(1));
          state_nxt = S_SHUP_WR;
        end
      end
      S_SHUP_WR: begin
        we        = 1'b1;
        waddr     = idx_r[AW-1:0];
        idx_nxt   = idx_r - CW'(1);
        state_nxt = S_SHUP_RD;
      end
      S_INS_WR: begin
        we        = 1'b1;
        wdata     = {key_s_r, key_e_r};
        occ_nxt   = occ_r + CW'(1);
        em_st_nxt = ST_OK;
        if (op_r == OP_MOVE) begin
          em_e_nxt = key_e_r;
          em_s_nxt = key_s_r;
        end
        state_nxt = S_EMIT1;
      end
      S_SHDN_RD: begin
        if (idx_r == occ_r) begin
          occ_nxt = pos_r;
          if (op_r == OP_MOVE) begin
            phase_nxt = 1'b1;
            key_s_nxt = ns_r;
            idx_nxt   = '0;
            state_nxt = S_SCAN_RD;
          end else if (rem_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_EMIT1;
          end
        end else begin
          re        = 1'b1;
          state_nxt = S_SHDN_WR;
        end
      end
      S_SHDN_WR: begin
        we        = 1'b1;
        pos_nxt   = pos_r + CW'(1);
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SHDN_RD;
      end
      S_RNG_RD: begin
        re        = 1'b1;
        raddr     = rng_addr[AW-1:0];
        state_nxt = S_RNG_EM;
      end
      S_RNG_EM: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_st_nxt   = ST_OK;
          o_e_nxt    = rd_e;
          o_s_nxt    = rd_s;
          o_cnt_nxt  = cnt_r;
          o_last_nxt = (idx_r == end_r);
          idx_nxt    = idx_r + CW'(1);
          if (idx_r != end_r) begin
            state_nxt = S_RNG_RD;
          end else if (rem_r) begin
            state_nxt = S_SHDN_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_st_nxt   = em_st_r;
          o_e_nxt    = em_e_r;
          o_s_nxt    = em_s_r;
          o_cnt_nxt  = occ_r;
          o_last_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/sv/ordered_score_set_tb.sv =====
`timescale 1ns / 100ps

module ordered_score_set_tb;
  import oss_pkg::*;

  localparam int CAP = 64;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]           status;
    logic [EW-1:0]        element;
    logic signed [SW-1:0] score;
    logic [RW-1:0]        count;
    logic                 last;
  } score_result_t;

  typedef struct {
    logic [2:0]           op;
    logic signed [SW-1:0] score;
    logic [EW-1:0]        element;
    logic signed [SW-1:0] new_score;
    logic [RW-1:0]        rank_lo;
    logic [RW-1:0]        rank_hi;
    bit                   typed;
    logic [1:0]           typed_status;
    logic [RW-1:0]        typed_count;
  } score_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  oss_in_if  in_ch ();
  oss_out_if out_ch ();
  oss_cfg_if cfg_ch ();

  ordered_score_set #(.CAPACITY(CAP)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  logic signed [SW-1:0] table_score [CAP];
  logic [EW-1:0]        table_element [CAP];
  int                   table_fill;
  bit                   reverse_read;

  score_result_t pending_results[$];
  int            error_count;
  int            cycle_count;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            recv_hold;
  int            hold_cycles;

  function automatic bit key_below(logic signed [SW-1:0] sa, logic [EW-1:0] ea,
                                   logic signed [SW-1:0] sb, logic [EW-1:0] eb);
    if (sa != sb) begin
      return sa < sb;
    end
    return ea < eb;
  endfunction

  function automatic int slot_for(logic signed [SW-1:0] s, logic [EW-1:0] e);
    int i;
    i = 0;
    while (i < table_fill && key_below(table_score[i], table_element[i], s, e)) begin
      i++;
    end
    return i;
  endfunction

  function automatic void drop_slot(int p);
    for (int i = p; i < table_fill - 1; i++) begin
      table_score[i] = table_score[i + 1];
      table_element[i] = table_element[i + 1];
    end
    table_fill--;
  endfunction

  function automatic void place_slot(int p, logic signed [SW-1:0] s, logic [EW-1:0] e);
    for (int i = table_fill; i > p; i--) begin
      table_score[i] = table_score[i - 1];
      table_element[i] = table_element[i - 1];
    end
    table_score[p] = s;
    table_element[p] = e;
    table_fill++;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [EW-1:0] e,
                                      logic signed [SW-1:0] s, bit lst);
    score_result_t r;
    r.status = st;
    r.element = e;
    r.score = s;
    r.count = table_fill[RW-1:0];
    r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_table(score_op_t o);
    int p, first, stop, n, idx;
    score_result_t r;
    case (o.op)
      OP_INSERT: begin
        if (table_fill >= CAP) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          place_slot(slot_for(o.score, o.element), o.score, o.element);
          push_result(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_DELETE, OP_MOVE: begin
        p = slot_for(o.score, o.element);
        if (!(p < table_fill && table_score[p] == o.score && table_element[p] == o.element)) begin
          push_result(ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          drop_slot(p);
          if (o.op == OP_DELETE) begin
            push_result(ST_OK, '0, '0, 1'b1);
          end else begin
            place_slot(slot_for(o.new_score, o.element), o.new_score, o.element);
            push_result(ST_OK, o.element, o.new_score, 1'b1);
          end
        end
      end
      OP_GET: begin
        if (o.rank_lo == 0 || o.rank_lo > table_fill) begin
          push_result(ST_NOTFOUND, '0, '0, 1'b1);
        end else begin
          push_result(ST_OK, table_element[o.rank_lo - 1], table_score[o.rank_lo - 1], 1'b1);
        end
      end
      OP_REMOVE: begin
        first = (o.rank_lo == 0) ? 1 : o.rank_lo;
        stop = (o.rank_hi > table_fill) ? table_fill : o.rank_hi;
        if (first > stop) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          n = stop - first + 1;
          for (int k = 0; k < n; k++) begin
            r.status = ST_OK;
            r.element = table_element[first - 1 + k];
            r.score = table_score[first - 1 + k];
            r.count = RW'(table_fill - n);
            r.last = (k + 1 == n);
            pending_results.push_back(r);
          end
          for (int k = 0; k < n; k++) begin
            drop_slot(first - 1);
          end
        end
      end
      OP_READ: begin
        if (o.rank_hi < o.rank_lo || o.rank_lo >= table_fill) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          stop = (o.rank_hi >= table_fill) ? table_fill - 1 : o.rank_hi;
          n = stop - o.rank_lo + 1;
          for (int k = 0; k < n; k++) begin
            idx = reverse_read ? table_fill - 1 - (o.rank_lo + k) : o.rank_lo + k;
            push_result(ST_OK, table_element[idx], table_score[idx], k + 1 == n);
          end
        end
      end
      default: begin
        push_result(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.score = '0;
    in_ch.element = '0;
    in_ch.new_score = '0;
    in_ch.rank_start = '0;
    in_ch.rank_end = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ordered_score_set regression: fail");
      $finish;
    end
  end

  // receiver side, with a long hold-off when requested
  always @(posedge clk) begin
    if (recv_hold) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    score_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d element %0d", out_ch.status,
               out_ch.out_element);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          error_count++;
        end
        if (out_ch.out_element !== exp_r.element) begin
          $error("out_element: expected %0d, got %0d", exp_r.element, out_ch.out_element);
          error_count++;
        end
        if (out_ch.out_score !== exp_r.score) begin
          $error("out_score: expected %0d, got %0d", exp_r.score, out_ch.out_score);
          error_count++;
        end
        if (out_ch.entry_count !== exp_r.count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.count, out_ch.entry_count);
          error_count++;
        end
        if (out_ch.last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  task automatic send_op(score_op_t o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= o.op;
    in_ch.score <= o.score;
    in_ch.element <= o.element;
    in_ch.new_score <= o.new_score;
    in_ch.rank_start <= o.rank_lo;
    in_ch.rank_end <= o.rank_hi;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    predict_table(o);
    if (o.typed) begin
      if (pending_results[$].status !== o.typed_status ||
          pending_results[$].count !== o.typed_count) begin
        $error("table row: expected status %0d count %0d", o.typed_status, o.typed_count);
        error_count++;
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * CAP + 20) @(posedge clk);
  endtask

  task automatic write_reverse(bit v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reverse_read = v;
  endtask

  function automatic score_op_t mk_op(logic [2:0] op, logic signed [SW-1:0] s,
                                      logic [EW-1:0] e, logic signed [SW-1:0] ns,
                                      int lo, int hi);
    score_op_t o;
    o.op = op;
    o.score = s;
    o.element = e;
    o.new_score = ns;
    o.rank_lo = RW'(lo);
    o.rank_hi = RW'(hi);
    o.typed = 1'b0;
    o.typed_status = ST_OK;
    o.typed_count = '0;
    return o;
  endfunction

  function automatic score_op_t mk_typed(score_op_t o, logic [1:0] st, int cnt);
    o.typed = 1'b1;
    o.typed_status = st;
    o.typed_count = RW'(cnt);
    return o;
  endfunction

  function automatic logic signed [SW-1:0] pick_score();
    case ($urandom_range(5))
      0: return {1'b1, 63'd0};
      1: return {1'b0, {63{1'b1}}};
      2: return {$urandom, $urandom};
      default: return SW'($signed($urandom_range(40))) - 20;
    endcase
  endfunction

  function automatic score_op_t random_op();
    score_op_t o;
    int p;
    int w;
    o = mk_op(OP_INSERT, pick_score(), EW'($urandom_range(7)), pick_score(),
              $urandom_range(66), $urandom_range(66));
    if ($urandom_range(9) == 0) begin
      o.element = $urandom;
    end
    w = $urandom_range(99);
    if (w < 35) begin
      o.op = OP_INSERT;
    end else if (w < 50) begin
      o.op = OP_DELETE;
    end else if (w < 62) begin
      o.op = OP_MOVE;
    end else if (w < 72) begin
      o.op = OP_GET;
    end else if (w < 78) begin
      o.op = OP_REMOVE;
      o.rank_hi = RW'(o.rank_lo + $urandom_range(4));
    end else if (w < 95) begin
      o.op = OP_READ;
      if ($urandom_range(1)) begin
        o.rank_hi = RW'(o.rank_lo + $urandom_range(6));
      end
    end else begin
      o.op = 3'($urandom_range(7, 6));
    end
    // mostly hit entries that exist
    if ((o.op == OP_DELETE || o.op == OP_MOVE) && table_fill > 0 && $urandom_range(3) != 0) begin
      p = $urandom_range(table_fill - 1);
      o.score = table_score[p];
      o.element = table_element[p];
    end
    return o;
  endfunction

  initial begin
    score_op_t rows[$];
    score_op_t o;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold = 1'b0;
    hold_cycles = 0;
    table_fill = 0;
    reverse_read = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back(mk_typed(mk_op(OP_GET, 0, 0, 0, 1, 0), ST_NOTFOUND, 0));
    rows.push_back(mk_typed(mk_op(OP_READ, 0, 0, 0, 0, 5), ST_EMPTY, 0));
    rows.push_back(mk_typed(mk_op(OP_REMOVE, 0, 0, 0, 0, 64), ST_EMPTY, 0));
    rows.push_back(mk_typed(mk_op(OP_DELETE, 5, 1, 0, 0, 0), ST_NOTFOUND, 0));
    rows.push_back(mk_typed(mk_op(OP_INSERT, {1'b1, 63'd0}, 32'hffff_ffff, 0, 0, 0), ST_OK, 1));
    rows.push_back(mk_typed(mk_op(OP_INSERT, {1'b0, {63{1'b1}}}, 0, 0, 0, 0), ST_OK, 2));
    rows.push_back(mk_typed(mk_op(OP_INSERT, 7, 3, 0, 0, 0), ST_OK, 3));
    rows.push_back(mk_typed(mk_op(OP_INSERT, 7, 3, 0, 0, 0), ST_OK, 4));
    rows.push_back(mk_typed(mk_op(OP_INSERT, 7, 1, 0, 0, 0), ST_OK, 5));
    rows.push_back(mk_typed(mk_op(OP_INSERT, -1, 2, 0, 0, 0), ST_OK, 6));
    rows.push_back(mk_op(OP_GET, 0, 0, 0, 1, 0));
    rows.push_back(mk_op(OP_GET, 0, 0, 0, 6, 0));
    rows.push_back(mk_typed(mk_op(OP_GET, 0, 0, 0, 7, 0), ST_NOTFOUND, 6));
    rows.push_back(mk_op(OP_MOVE, 7, 1, {1'b1, 63'd5}, 0, 0));
    rows.push_back(mk_typed(mk_op(OP_MOVE, 9, 9, 0, 0, 0), ST_NOTFOUND, 6));
    rows.push_back(mk_op(OP_READ, 0, 0, 0, 0, 127));
    rows.push_back(mk_typed(mk_op(OP_READ, 0, 0, 0, 4, 2), ST_EMPTY, 6));
    rows.push_back(mk_typed(mk_op(3'd6, 1, 1, 1, 1, 1), ST_OK, 6));
    rows.push_back(mk_typed(mk_op(3'd7, -1, '1, -1, 127, 127), ST_OK, 6));
    rows.push_back(mk_typed(mk_op(OP_DELETE, 7, 3, 0, 0, 0), ST_OK, 5));
    rows.push_back(mk_op(OP_REMOVE, 0, 0, 0, 0, 2));
    rows.push_back(mk_op(OP_REMOVE, 0, 0, 0, 2, 127));
    foreach (rows[i]) begin
      send_op(rows[i]);
    end
    drain_results();

    // fill to capacity, then overflow
    for (int i = 0; i < CAP; i++) begin
      send_op(mk_op(OP_INSERT, SW'($signed($urandom_range(30))) - 15, $urandom_range(3), 0, 0, 0));
    end
    send_op(mk_typed(mk_op(OP_INSERT, 0, 0, 0, 0, 0), ST_FULL, CAP));
    drain_results();
    write_reverse(1'b1);
    send_op(mk_op(OP_READ, 0, 0, 0, 0, 127));
    send_op(mk_op(OP_READ, 0, 0, 0, 60, 70));
    drain_results();
    write_reverse(1'b0);
    send_op(mk_op(OP_READ, 0, 0, 0, 0, 63));
    send_op(mk_op(OP_REMOVE, 0, 0, 0, 1, 127));

    // long receiver hold while the sender keeps offering
    fork
      begin
        recv_hold = 1'b1;
        wait (hold_cycles >= 400);
        recv_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) begin
          send_op(mk_op(OP_INSERT, i, i, 0, 0, 0));
        end
        send_op(mk_op(OP_READ, 0, 0, 0, 0, 20));
      end
    join
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        3: begin send_idle_pct = 28; recv_stall_pct = 28; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 24; i++) begin
        o = random_op();
        send_op(o);
      end
      drain_results();
      write_reverse(ph[0] ^ 1'b1);
    end

    if (error_count == 0) begin
      $display("ordered_score_set regression: pass");
    end else begin
      $display("ordered_score_set regression: fail");
    end
    $finish;
  end

endmodule

// ===== ordered_score_set.f =====
design/oss_pkg.sv
design/oss_if.sv
design/oss_ram.sv
design/oss_cmp.sv
design/ordered_score_set.sv
tb/sv/ordered_score_set_tb.sv
